@@ design/swtr_pkg.sv @@
// Shared constants, register codes and types of the sliding-window trimmed range unit.
// No dependencies; imported by sliding_window_trimmed_range_unit, swtr_engine and the testbench.
`default_nettype none

package swtr_pkg;

    localparam int LOCK_WINDOW = 64;
    localparam int WIN_AW      = (LOCK_WINDOW > 1) ? $clog2(LOCK_WINDOW) : 1;
    localparam int SORT_AW     = WIN_AW + 1;
    localparam int FILL_W      = $clog2(LOCK_WINDOW + 1);

    localparam int LOCK_W   = 16;
    localparam int SAMPLE_W = 17;
    localparam int CENTRE_W = 17;
    localparam int RADIUS_W = 16;
    localparam int TOTAL_W  = 32;
    localparam int THR_W    = 7;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_LOCKS_BEFORE_HINT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RADIUS        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RADIUS        = 2'd2;

    localparam logic [THR_W-1:0]    RST_LOCKS_BEFORE_HINT = 7'd16;
    localparam logic [RADIUS_W-1:0] RST_MIN_RADIUS        = 16'd64;
    localparam logic [RADIUS_W-1:0] RST_MAX_RADIUS        = 16'd256;

    // floor(n/20) == (n*205) >> 12 for every n up to 256
    localparam int TRIM_MUL    = 205;
    localparam int TRIM_SHIFT  = 12;
    localparam int TRIM_PROD_W = TRIM_SHIFT + FILL_W;

    localparam int S_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;
    localparam int M_PAY_W   = CENTRE_W + RADIUS_W + TOTAL_W;
    localparam int M_TDATA_W = ((M_PAY_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 2;

    typedef struct packed {
        logic [THR_W-1:0]    locks_before_hint;
        logic [RADIUS_W-1:0] min_radius;
        logic [RADIUS_W-1:0] max_radius;
    } swtr_cfg_t;

    typedef struct packed {
        logic                hint_valid;
        logic [CENTRE_W-1:0] hint_centre;
        logic [RADIUS_W-1:0] hint_radius;
        logic                hint_updated;
        logic [TOTAL_W-1:0]  total_locks;
    } swtr_result_t;

endpackage

`default_nettype wire

@@ design/sliding_window_trimmed_range_unit.sv @@
// Sliding-window trimmed range unit: per-line lock positions in, trimmed-range hint out.
// An accepted item (line_valid set, lock position non-negative) runs a merge pass that
// rebuilds the sorted copy of the window in its RAM, one entry per cycle apart from the cycle
// that skips the evicted entry, followed by two reads of the trimmed ends and the hint math;
// the reads and the math are skipped while the fill is below locks_before_hint.
// A rejected item skips all of this. No clearing pass runs after reset. One result item comes
// out per input item; the result register lets the engine finish while the last result waits.
// Depends on swtr_pkg and swtr_engine.
`default_nettype none

module sliding_window_trimmed_range_unit import swtr_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [16:0] lock_pos
    input  wire logic                  s_tuser,   // [0] line_valid
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_TDATA_W-1:0]  m_tdata,   // [16:0] centre, [32:17] radius, [64:33] total
    output logic      [M_TUSER_W-1:0]  m_tuser,   // [0] hint_valid, [1] hint_updated
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    swtr_cfg_t            cfg_reg;
    swtr_result_t         result;
    logic                 eng_idle, res_valid, res_take, start, is_lock;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.locks_before_hint <= RST_LOCKS_BEFORE_HINT;
            cfg_reg.min_radius        <= RST_MIN_RADIUS;
            cfg_reg.max_radius        <= RST_MAX_RADIUS;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_LOCKS_BEFORE_HINT: begin
                    cfg_reg.locks_before_hint <= cfg_data[THR_W-1:0];
                end
                REG_MIN_RADIUS: begin
                    cfg_reg.min_radius <= cfg_data[RADIUS_W-1:0];
                end
                REG_MAX_RADIUS: begin
                    cfg_reg.max_radius <= cfg_data[RADIUS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign s_tready = eng_idle;
    assign start    = s_tvalid & eng_idle;
    assign is_lock  = s_tuser & ~s_tdata[SAMPLE_W-1];

    swtr_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (start),
        .is_lock    (is_lock),
        .lock_value (s_tdata[LOCK_W-1:0]),
        .cfg        (cfg_reg),
        .idle       (eng_idle),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .result     (result)
    );

    assign res_take = res_valid & (~m_tvalid_reg | m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_take) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (res_take) begin
            m_tdata_reg <= M_TDATA_W'({result.total_locks, result.hint_radius,
                                       result.hint_centre});
            m_tuser_reg <= {result.hint_updated, result.hint_valid};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

@@ design/swtr_ram.sv @@
// Generic simple dual-port synchronous RAM, one write and one registered read per cycle.
// No dependencies.
`default_nettype none

module swtr_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ design/swtr_engine.sv @@
// Window engine: arrival-order window RAM, ping-pong sorted-copy RAM, merge pass and hint math.
// Depends on swtr_pkg and swtr_ram.
`default_nettype none

module swtr_engine import swtr_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic              is_lock,
    input  wire logic [LOCK_W-1:0] lock_value,
    input  wire swtr_cfg_t         cfg,
    output logic                   idle,
    output logic                   res_valid,
    input  wire logic              res_take,
    output swtr_result_t           result
);

    localparam int CMP_W = (FILL_W > THR_W) ? FILL_W : THR_W;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_MERGE, S_TRIM_LO, S_TRIM_HI, S_CALC, S_CHECK, S_FINISH
    } state_t;

    state_t               state_reg, state_next;
    logic [WIN_AW-1:0]    slot_reg, slot_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [CENTRE_W-1:0]  centre_reg, centre_next;
    logic [RADIUS_W-1:0]  radius_reg, radius_next;
    logic                 valid_reg, valid_next;
    logic                 updated_reg, updated_next;
    logic                 bank_reg, bank_next;
    logic [LOCK_W-1:0]    new_reg, new_next;
    logic [LOCK_W-1:0]    old_reg, old_next;
    logic [LOCK_W-1:0]    low_reg, low_next;
    logic [FILL_W-1:0]    n_old_reg, n_old_next;
    logic [FILL_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [FILL_W-1:0]    wr_idx_reg, wr_idx_next;
    logic [FILL_W-1:0]    trim_reg, trim_next;
    logic                 inserted_reg, inserted_next;
    logic                 removed_reg, removed_next;

    logic                 win_we;
    logic [LOCK_W-1:0]    win_q;
    logic                 srt_we;
    logic [SORT_AW-1:0]   srt_waddr, srt_raddr;
    logic [LOCK_W-1:0]    srt_wdata, srt_q;

    logic [FILL_W-1:0]      fill_inc, rd_inc, hi_idx;
    logic [WIN_AW-1:0]      slot_inc;
    logic [TRIM_PROD_W-1:0] trim_prod;
    logic                   have_x, match_old, take_new, merge_done, thr_hit;
    logic [LOCK_W-1:0]      diff;

    swtr_ram #(.DEPTH(LOCK_WINDOW), .WIDTH(LOCK_W)) u_win_ram (
        .aclk  (aclk),
        .we    (win_we),
        .waddr (slot_reg),
        .wdata (new_reg),
        .raddr (slot_reg),
        .rdata (win_q)
    );

    // two banks: current sorted copy is read while the merged copy fills the other
    swtr_ram #(.DEPTH(2 ** SORT_AW), .WIDTH(LOCK_W)) u_sort_ram (
        .aclk  (aclk),
        .we    (srt_we),
        .waddr (srt_waddr),
        .wdata (srt_wdata),
        .raddr (srt_raddr),
        .rdata (srt_q)
    );

    assign fill_inc  = (fill_reg == FILL_W'(LOCK_WINDOW)) ? fill_reg : fill_reg + 1'b1;
    assign slot_inc  = (slot_reg == WIN_AW'(LOCK_WINDOW - 1)) ? '0 : slot_reg + 1'b1;
    assign trim_prod = TRIM_PROD_W'(fill_inc) * TRIM_PROD_W'(TRIM_MUL);
    assign rd_inc    = rd_idx_reg + 1'b1;
    assign hi_idx    = fill_reg - FILL_W'(1) - trim_reg;
    assign diff      = srt_q - low_reg;

    assign have_x     = rd_idx_reg < n_old_reg;
    assign match_old  = have_x && !removed_reg && (srt_q == old_reg);
    assign take_new   = !inserted_reg && (!have_x || (new_reg <= srt_q));
    assign merge_done = !have_x && inserted_reg;
    assign thr_hit    = CMP_W'(fill_reg) >= CMP_W'(cfg.locks_before_hint);

    always_comb begin
        state_next    = state_reg;
        slot_next     = slot_reg;
        fill_next     = fill_reg;
        total_next    = total_reg;
        centre_next   = centre_reg;
        radius_next   = radius_reg;
        valid_next    = valid_reg;
        updated_next  = updated_reg;
        bank_next     = bank_reg;
        new_next      = new_reg;
        old_next      = old_reg;
        low_next      = low_reg;
        n_old_next    = n_old_reg;
        rd_idx_next   = rd_idx_reg;
        wr_idx_next   = wr_idx_reg;
        trim_next     = trim_reg;
        inserted_next = inserted_reg;
        removed_next  = removed_reg;
        win_we        = 1'b0;
        srt_we        = 1'b0;
        srt_wdata     = new_reg;
        srt_waddr     = {~bank_reg, wr_idx_reg[WIN_AW-1:0]};
        srt_raddr     = {bank_reg, rd_idx_reg[WIN_AW-1:0]};

        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    if (is_lock) begin
                        new_next   = lock_value;
                        n_old_next = fill_reg;
                        state_next = S_LOAD;
                    end else begin
                        updated_next = 1'b0;
                        state_next   = S_FINISH;
                    end
                end
            end
            S_LOAD: begin
                old_next      = win_q;
                win_we        = 1'b1;
                slot_next     = slot_inc;
                fill_next     = fill_inc;
                trim_next     = trim_prod[TRIM_SHIFT +: FILL_W];
                total_next    = (&total_reg) ? total_reg : total_reg + 1'b1;
                rd_idx_next   = '0;
                wr_idx_next   = '0;
                inserted_next = 1'b0;
                removed_next  = (n_old_reg != FILL_W'(LOCK_WINDOW));
                srt_raddr     = {bank_reg, {WIN_AW{1'b0}}};
                state_next    = S_MERGE;
            end
            S_MERGE: begin
                if (merge_done) begin
                    bank_next = ~bank_reg;
                    if (thr_hit) begin
                        state_next = S_TRIM_LO;
                    end else begin
                        updated_next = 1'b0;
                        state_next   = S_FINISH;
                    end
                end else if (match_old) begin
                    removed_next = 1'b1;
                    rd_idx_next  = rd_inc;
                    srt_raddr    = {bank_reg, rd_inc[WIN_AW-1:0]};
                end else if (take_new) begin
                    srt_we        = 1'b1;
                    inserted_next = 1'b1;
                    wr_idx_next   = wr_idx_reg + 1'b1;
                end else begin
                    srt_we      = 1'b1;
                    srt_wdata   = srt_q;
                    wr_idx_next = wr_idx_reg + 1'b1;
                    rd_idx_next = rd_inc;
                    srt_raddr   = {bank_reg, rd_inc[WIN_AW-1:0]};
                end
            end
            S_TRIM_LO: begin
                srt_raddr  = {bank_reg, trim_reg[WIN_AW-1:0]};
                state_next = S_TRIM_HI;
            end
            S_TRIM_HI: begin
                low_next   = srt_q;
                srt_raddr  = {bank_reg, hi_idx[WIN_AW-1:0]};
                state_next = S_CALC;
            end
            S_CALC: begin
                centre_next = CENTRE_W'(low_reg) + CENTRE_W'(srt_q);
                radius_next = (diff < cfg.min_radius) ? cfg.min_radius : diff;
                state_next  = S_CHECK;
            end
            S_CHECK: begin
                valid_next   = (radius_reg <= cfg.max_radius);
                updated_next = 1'b1;
                state_next   = S_FINISH;
            end
            S_FINISH: begin
                if (res_take) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            slot_reg    <= '0;
            fill_reg    <= '0;
            total_reg   <= '0;
            centre_reg  <= '0;
            radius_reg  <= '0;
            valid_reg   <= 1'b0;
            updated_reg <= 1'b0;
            bank_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            slot_reg    <= slot_next;
            fill_reg    <= fill_next;
            total_reg   <= total_next;
            centre_reg  <= centre_next;
            radius_reg  <= radius_next;
            valid_reg   <= valid_next;
            updated_reg <= updated_next;
            bank_reg    <= bank_next;
        end
        new_reg      <= new_next;
        old_reg      <= old_next;
        low_reg      <= low_next;
        n_old_reg    <= n_old_next;
        rd_idx_reg   <= rd_idx_next;
        wr_idx_reg   <= wr_idx_next;
        trim_reg     <= trim_next;
        inserted_reg <= inserted_next;
        removed_reg  <= removed_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_FINISH);

    assign result.hint_valid   = valid_reg;
    assign result.hint_centre  = centre_reg;
    assign result.hint_radius  = radius_reg;
    assign result.hint_updated = updated_reg;
    assign result.total_locks  = total_reg;

    a_merge_write_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MERGE && srt_we) |-> (wr_idx_reg < fill_reg))
        else $error("merge writes past the window fill");

    a_merge_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MERGE && merge_done) |-> (wr_idx_reg == fill_reg && removed_reg))
        else $error("merge ended with wrong length or evicted lock not found");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(LOCK_WINDOW))
        else $error("fill count beyond window depth");

    a_trim_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TRIM_LO) |-> (trim_reg <= hi_idx))
        else $error("trimmed low index above high index");

endmodule

`default_nettype wire

@@ test/tb_sliding_window_trimmed_range_unit.sv @@
// Testbench for sliding_window_trimmed_range_unit: drives line items, predicts each hint in
// a behavioral model of the trimmed window and checks every result item field by field.
// Depends on swtr_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_sliding_window_trimmed_range_unit;
    import swtr_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int IDLE_PCT    = 28;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_ready;

    sliding_window_trimmed_range_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // hint model state
    logic [THR_W-1:0]    thr_model   = RST_LOCKS_BEFORE_HINT;
    logic [RADIUS_W-1:0] min_model   = RST_MIN_RADIUS;
    logic [RADIUS_W-1:0] max_model   = RST_MAX_RADIUS;
    logic [LOCK_W-1:0]   lock_win [LOCK_WINDOW];
    logic [WIN_AW-1:0]   win_slot    = '0;
    int                  win_fill    = 0;
    logic [TOTAL_W-1:0]  lock_total  = '0;
    logic [CENTRE_W-1:0] held_centre = '0;
    logic [RADIUS_W-1:0] held_radius = '0;
    logic                held_valid  = 1'b0;

    swtr_result_t hint_q[$];
    swtr_result_t want;
    int  errors  = 0;
    int  cycles  = 0;
    bit  idle_en = 1'b1;
    int  cluster_base = 20000;
    int  cluster_span = 100;

    function automatic swtr_result_t predict_hint(input logic lv, input logic [SAMPLE_W-1:0] lk);
        logic [LOCK_W-1:0] ordered [LOCK_WINDOW];
        logic [LOCK_W-1:0] key;
        logic [LOCK_W-1:0] lo;
        logic [LOCK_W-1:0] hi;
        logic [RADIUS_W-1:0] spread;
        swtr_result_t res;
        int n;
        int trim;
        int i;
        int j;
        res.hint_updated = 1'b0;
        if (lv && !lk[SAMPLE_W-1]) begin
            lock_win[win_slot] = lk[LOCK_W-1:0];
            win_slot = win_slot + 1'b1;
            if (win_fill < LOCK_WINDOW) win_fill++;
            if (lock_total != '1) lock_total++;
            if (win_fill >= thr_model) begin
                n = win_fill;
                for (i = 0; i < n; i++) ordered[i] = lock_win[i];
                for (i = 1; i < n; i++) begin
                    key = ordered[i];
                    j = i;
                    while (j > 0 && ordered[j-1] > key) begin
                        ordered[j] = ordered[j-1];
                        j--;
                    end
                    ordered[j] = key;
                end
                trim = n / 20;
                lo = ordered[trim];
                hi = ordered[n-1-trim];
                spread = hi - lo;
                if (spread < min_model) spread = min_model;
                held_centre = {1'b0, lo} + {1'b0, hi};
                held_radius = spread;
                held_valid  = (spread <= max_model);
                res.hint_updated = 1'b1;
            end
        end
        res.hint_valid  = held_valid;
        res.hint_centre = held_centre;
        res.hint_radius = held_radius;
        res.total_locks = lock_total;
        return res;
    endfunction

    task automatic send_item(input logic lv, input logic [SAMPLE_W-1:0] lk);
        while (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= lv;
        s_tdata  <= {{(S_TDATA_W-SAMPLE_W){1'b0}}, lk};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        hint_q.push_back(predict_hint(lv, lk));
    endtask

    task automatic wait_idle;
        s_tvalid <= 1'b0;
        while (hint_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val,
                             input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (last) cfg_valid <= 1'b0;
        case (idx)
            REG_LOCKS_BEFORE_HINT: thr_model = val[THR_W-1:0];
            REG_MIN_RADIUS:        min_model = val;
            REG_MAX_RADIUS:        max_model = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] thr, input logic [CFG_DATA_W-1:0] minr,
                              input logic [CFG_DATA_W-1:0] maxr);
        wait_idle();
        write_reg(REG_LOCKS_BEFORE_HINT, thr, 1'b0);
        write_reg(REG_MIN_RADIUS, minr, 1'b0);
        write_reg(REG_MAX_RADIUS, maxr, 1'b1);
    endtask

    // mostly clustered locks, with outliers, rejected lines and negative locks
    task automatic next_line(output logic lv, output logic [SAMPLE_W-1:0] lk);
        int r;
        int pos;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 3) begin
            cluster_base = $urandom_range(0, 65535);
            case ($urandom_range(0, 3))
                0: cluster_span = $urandom_range(0, 20);
                1: cluster_span = $urandom_range(0, 200);
                2: cluster_span = $urandom_range(0, 800);
                default: cluster_span = $urandom_range(0, 65535);
            endcase
        end
        lv = (r >= 8);
        if (r >= 8 && r < 14) begin
            lk = {1'b1, 16'($urandom)};
        end else if (r < 20) begin
            lk = {1'b0, 16'($urandom)};
        end else begin
            pos = cluster_base + $urandom_range(0, cluster_span) - cluster_span / 2;
            if (pos < 0) pos = 0;
            if (pos > 65535) pos = 65535;
            lk = {1'b0, 16'(pos)};
        end
    endtask

    task automatic run_lines(input int count);
        logic lv;
        logic [SAMPLE_W-1:0] lk;
        repeat (count) begin
            next_line(lv, lk);
            send_item(lv, lk);
        end
        wait_idle();
    endtask

    task automatic test_rejected_lines;
        send_item(1'b0, 17'd100);
        send_item(1'b1, 17'h1FFFF);
        send_item(1'b1, 17'h10000);
        send_item(1'b0, 17'hFFFF);
        wait_idle();
    endtask

    task automatic test_extremes;
        // upper bits of the threshold write are dropped
        set_config(16'hFF83, 16'd0, 16'hFFFF);
        send_item(1'b1, 17'd0);
        send_item(1'b1, 17'hFFFF);
        send_item(1'b1, 17'hFFFF);
        send_item(1'b1, 17'd0);
        set_config(16'd1, 16'hFFFF, 16'hFFFE);
        send_item(1'b1, 17'd32768);
        set_config(16'd1, 16'd100, 16'd100);
        send_item(1'b1, 17'd50);
        wait_idle();
    endtask

    task automatic test_threshold_zero;
        set_config(16'd0, 16'd0, 16'd0);
        send_item(1'b1, 17'd1);
        send_item(1'b0, 17'd7);
        send_item(1'b1, 17'd1);
        wait_idle();
    endtask

    task automatic test_threshold_above_window;
        set_config(16'd65, 16'd64, 16'd256);
        send_item(1'b1, 17'd400);
        set_config(16'd127, 16'd64, 16'd256);
        send_item(1'b1, 17'd401);
        wait_idle();
    endtask

    task automatic test_unknown_register;
        wait_idle();
        write_reg(REG_UNUSED, 16'd1, 1'b1);
        send_item(1'b1, 17'd402);
        send_item(1'b0, 17'd0);
        wait_idle();
    endtask

    task automatic test_random_reset_config;
        set_config(16'(RST_LOCKS_BEFORE_HINT), RST_MIN_RADIUS, RST_MAX_RADIUS);
        run_lines(300);
    endtask

    task automatic test_random_back_to_back;
        set_config(16'd1, 16'd0, 16'd0);
        idle_en = 1'b0;
        run_lines(200);
        idle_en = 1'b1;
    endtask

    task automatic test_random_full_window;
        set_config(16'd64, 16'hFFFF, 16'hFFFF);
        run_lines(250);
    endtask

    task automatic test_random_config;
        repeat (4) begin
            set_config(16'($urandom_range(1, 64)), 16'($urandom_range(0, 400)),
                       16'($urandom_range(0, 1000)));
            run_lines(60);
        end
    endtask

    task automatic test_random_tight_clusters;
        set_config(16'd40, 16'd32, 16'd512);
        cluster_span = 30;
        run_lines(210);
    endtask

    function automatic void check_field(input string name, input longint exp_v, input longint got_v);
        if (exp_v != got_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (hint_q.size() == 0) begin
                $error("result item with no expectation pending");
                errors++;
            end else begin
                want = hint_q.pop_front();
                check_field("hint_centre", longint'(want.hint_centre),
                            longint'(m_tdata[CENTRE_W-1:0]));
                check_field("hint_radius", longint'(want.hint_radius),
                            longint'(m_tdata[CENTRE_W+RADIUS_W-1:CENTRE_W]));
                check_field("total_locks", longint'(want.total_locks),
                            longint'(m_tdata[M_PAY_W-1:CENTRE_W+RADIUS_W]));
                check_field("hint_valid", longint'(want.hint_valid), longint'(m_tuser[0]));
                check_field("hint_updated", longint'(want.hint_updated), longint'(m_tuser[1]));
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= !idle_en || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_rejected_lines();
        test_extremes();
        test_threshold_zero();
        test_threshold_above_window();
        test_unknown_register();
        test_random_reset_config();
        test_random_back_to_back();
        test_random_full_window();
        test_random_config();
        test_random_tight_clusters();
        wait_idle();
        repeat (LOCK_WINDOW + 16) @(posedge aclk);
        if (hint_q.size() != 0) begin
            $error("%0d expected results never arrived", hint_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
